// File: rtl/core/dtp_pkg.sv
// Shared types, constants and arithmetic helpers of the depth to point cloud block.
// Used by every module in rtl/core; depends on nothing else.
package dtp_pkg;

   // Field widths of the request and result channels.
   localparam int PIX_W    = 17;
   localparam int DIR_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int COORD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 15;
   localparam int ENTRY_W  = 3 * DIR_W;

   // Operation codes carried in the request tuser field.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // Conversion modes.
   localparam logic MODE_DEPTH = 1'b0;
   localparam logic MODE_RANGE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   // Reset values of the registers.
   localparam logic               MODE_RESET  = MODE_DEPTH;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

   // Divider geometry: a 36-bit dividend, a 16-bit divisor, two quotient bits per stage.
   localparam int LANES          = 2;
   localparam int NUM_W          = 36;
   localparam int DEN_W          = 16;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = NUM_W / BITS_PER_STAGE;

   // Divisor used in range mode (Q2.14 times Q16.0 down to Q28.4).
   localparam logic [DEN_W-1:0] DEN_RANGE = 16'd1024;
   localparam logic [DEN_W-1:0] DEN_ONE   = 16'd1;

   // Output buffer, sized above the pipeline latency so full rate holds.
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = 5;

   // Quotient bounds for signed 32-bit saturation.
   localparam logic [NUM_W-1:0]   Q_MAX_POS = 36'h0_7FFF_FFFF;
   localparam logic [NUM_W-1:0]   Q_MAX_NEG = 36'h0_8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   // Sideband that travels with an item through the divider.
   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic               zero;
      logic [COORD_W-1:0] pz;
   } side_type;

   // One finished result.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  pz;
      logic [COORD_W-1:0]  py;
      logic [COORD_W-1:0]  px;
   } result_type;

   // One restoring division step: returns the quotient bit over the new remainder.
   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {1'b1, diff[DEN_W-1:0]};
      end
      return {1'b0, trial[DEN_W-1:0]};
   endfunction

   // Applies the sign to a quotient magnitude and clamps it; returns saturation over value.
   function automatic logic [COORD_W:0] clamp_coord(input logic [NUM_W-1:0] q,
                                                    input logic neg);
      if (neg) begin
         if (q > Q_MAX_NEG) begin
            return {1'b1, COORD_MIN};
         end
         return {1'b0, COORD_W'(32'd0 - q[COORD_W-1:0])};
      end
      if (q > Q_MAX_POS) begin
         return {1'b1, COORD_MAX};
      end
      return {1'b0, q[COORD_W-1:0]};
   endfunction

endpackage

// File: rtl/core/depth_to_point_cloud.sv
// Depth to point cloud converter: direction table, products, pipelined divider, output buffer.
// A convert request passes the table read, the front stages and the divider into the output buffer.
// Throughput is one request per cycle while credits remain; the 32-entry output buffer and a
// credit count set how many results may be outstanding while the consumer stalls.
// Reset clears the pipeline valid bits, the buffer and the registers (mode 0, limit 2);
// the direction table has no reset and no clearing pass, it is valid once loaded.
module depth_to_point_cloud import dtp_pkg::*; #(
   parameter int PIXELS = 131072
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // pixel_index[16:0], dir_x[32:17], dir_y[48:33],
                                    // dir_z[64:49], sample[80:65], zero fill
   input  logic        req_tuser,   // operation[0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int CMP_W  = ((ADDR_W > PIX_W) ? ADDR_W : PIX_W) + 1;

   logic               mode_ff, mode_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_write;

   logic               accept;
   logic               accept_conv;
   logic               pop;
   logic [FIFO_AW:0]   credit_ff, credit_in;

   logic [PIX_W-1:0]    pixel_index;
   logic [SAMPLE_W-1:0] sample;
   logic [ENTRY_W-1:0]  entry_wr;
   logic [CMP_W-1:0]    idx_wide;
   logic                idx_in_range;
   logic [ENTRY_W-1:0]  entry_rd;

   logic                conv_v_ff;
   logic                in_range_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   logic                        front_valid;
   logic [LANES-1:0][NUM_W-1:0] front_num;
   logic [DEN_W-1:0]            front_den;
   side_type                    front_side;

   logic                        div_valid;
   logic [LANES-1:0][NUM_W-1:0] div_quo;
   side_type                    div_side;

   logic [COORD_W:0] clamp_x, clamp_y;
   result_type       result;
   result_type       fifo_data;

   // Configuration registers.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MODE:  mode_in  = csr_pwdata[0];
            REG_LIMIT: limit_in = csr_pwdata[LIMIT_W-1:0];
            default:   mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         mode_ff  <= mode_in;
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_LIMIT) ? {17'd0, limit_ff} : {31'd0, mode_ff};

   // Request decode and credit accounting for outstanding convert results.
   assign pixel_index  = req_tdata[16:0];
   assign entry_wr     = req_tdata[64:17];
   assign sample       = req_tdata[80:65];
   assign idx_wide     = CMP_W'(pixel_index);
   assign idx_in_range = (idx_wide < CMP_W'(PIXELS));

   assign req_tready  = (credit_ff != (FIFO_AW+1)'(FIFO_DEPTH));
   assign accept      = req_tvalid && req_tready;
   assign accept_conv = accept && (req_tuser == OP_CONVERT);
   assign pop         = rsp_tvalid && rsp_tready;
   assign credit_in   = credit_ff + {{FIFO_AW{1'b0}}, accept_conv} - {{FIFO_AW{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         conv_v_ff <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         conv_v_ff <= accept_conv;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff <= idx_in_range;
      sample_ff   <= sample;
   end

   // Direction table: loads write, converts read.
   dtp_dir_table #(
      .PIXELS (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == OP_LOAD) && idx_in_range),
      .wr_addr (idx_wide[ADDR_W-1:0]),
      .wr_data (entry_wr),
      .rd_en   (accept_conv),
      .rd_addr (idx_wide[ADDR_W-1:0]),
      .rd_data (entry_rd)
   );

   dtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_v_ff),
      .in_range  (in_range_ff),
      .sample    (sample_ff),
      .entry     (entry_rd),
      .mode      (mode_ff),
      .limit     (limit_ff),
      .out_valid (front_valid),
      .out_num   (front_num),
      .out_den   (front_den),
      .out_side  (front_side)
   );

   dtp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // Sign, saturation and status of the finished quotients.
   always_comb begin
      clamp_x = clamp_coord(div_quo[0], div_side.neg_x);
      clamp_y = clamp_coord(div_quo[1], div_side.neg_y);
      result.pz = div_side.pz;
      if (div_side.zero) begin
         result.px     = '0;
         result.py     = '0;
         result.status = STATUS_ZERO;
      end else begin
         result.px     = clamp_x[COORD_W-1:0];
         result.py     = clamp_y[COORD_W-1:0];
         result.status = (clamp_x[COORD_W] || clamp_y[COORD_W]) ? STATUS_SAT : STATUS_OK;
      end
   end

   dtp_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (div_valid),
      .push_data (result),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_data)
   );

   assign rsp_tdata = {fifo_data.pz, fifo_data.py, fifo_data.px};
   assign rsp_tuser = fifo_data.status;

   // The credit count never passes the buffer depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("credit count above buffer depth");

   // A result on the response side is always covered by an outstanding credit.
   a_valid_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (credit_ff != '0))
      else $error("response valid without an outstanding request");

   // An accepted convert request takes one credit.
   a_convert_credit: assert property (@(posedge clock) disable iff (reset)
      (accept_conv && !pop) |=> (credit_ff == $past(credit_ff) + 1'b1))
      else $error("convert request did not take a credit");

   // A load request takes no credit.
   a_load_no_credit: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_LOAD) && !pop) |=> $stable(credit_ff))
      else $error("load request changed the credit count");

endmodule

// File: rtl/core/dtp_dir_table.sv
// Per-pixel direction memory with one write port and one registered read port.
// Depends on dtp_pkg for the entry width.
module dtp_dir_table import dtp_pkg::*; #(
   parameter int PIXELS = 131072,
   parameter int ADDR_W = 17
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [PIXELS];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/dtp_front.sv
// Front end of the conversion: products, ray check, divisor, then dividend and z.
// Two register stages; depends on dtp_pkg.
module dtp_front import dtp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_range,
   input  logic [SAMPLE_W-1:0]           sample,
   input  logic [ENTRY_W-1:0]            entry,
   input  logic                          mode,
   input  logic [LIMIT_W-1:0]            limit,
   output logic                          out_valid,
   output logic [LANES-1:0][NUM_W-1:0]   out_num,
   output logic [DEN_W-1:0]              out_den,
   output side_type                      out_side
);

   // Stage A registers.
   logic                valid_a_ff;
   logic [COORD_W-1:0]  prod_x_ff, prod_x_in;
   logic [COORD_W-1:0]  prod_y_ff, prod_y_in;
   logic [COORD_W-1:0]  prod_z_ff, prod_z_in;
   logic [SAMPLE_W-1:0] sample_a_ff;
   logic [DEN_W-1:0]    den_a_ff, den_a_in;
   logic                zero_a_ff, zero_a_in;
   logic                mode_a_ff;

   // Stage B registers.
   logic                        valid_b_ff;
   logic [LANES-1:0][NUM_W-1:0] num_b_ff, num_b_in;
   logic [DEN_W-1:0]            den_b_ff;
   side_type                    side_b_ff, side_b_in;

   logic signed [DIR_W-1:0]    dx, dy, dz;
   logic signed [SAMPLE_W:0]   samp_s;
   logic signed [COORD_W:0]    full_x, full_y, full_z;
   logic [DIR_W+1:0]           zsum;
   logic [DIR_W:0]             dz_neg;
   logic [COORD_W-1:0]         mag_x, mag_y, mag_z;
   logic [COORD_W:0]           zround;
   logic [COORD_W-1:0]         zmag;
   logic [COORD_W-1:0]         pz_calc;

   // Stage A: direction times sample, ray test against the limit, divisor choice.
   always_comb begin
      dx      = in_range ? $signed(entry[DIR_W-1:0]) : '0;
      dy      = in_range ? $signed(entry[2*DIR_W-1:DIR_W]) : '0;
      dz      = in_range ? $signed(entry[3*DIR_W-1:2*DIR_W]) : '0;
      samp_s  = $signed({1'b0, sample});
      full_x  = dx * samp_s;
      full_y  = dy * samp_s;
      full_z  = dz * samp_s;
      prod_x_in = full_x[COORD_W-1:0];
      prod_y_in = full_y[COORD_W-1:0];
      prod_z_in = full_z[COORD_W-1:0];
      // The ray is usable when dz + limit is negative.
      zsum   = {{2{dz[DIR_W-1]}}, dz} + {3'b000, limit};
      dz_neg = (DIR_W+1)'(0) - {dz[DIR_W-1], dz};
      zero_a_in = (mode == MODE_DEPTH) && !zsum[DIR_W+1];
      if (mode == MODE_RANGE) begin
         den_a_in = DEN_RANGE;
      end else if (zero_a_in) begin
         den_a_in = DEN_ONE;
      end else begin
         den_a_in = dz_neg[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      prod_z_ff   <= prod_z_in;
      sample_a_ff <= sample;
      den_a_ff    <= den_a_in;
      zero_a_ff   <= zero_a_in;
      mode_a_ff   <= mode;
   end

   // Stage B: magnitudes, rounded dividends, and the finished z coordinate.
   always_comb begin
      mag_x  = prod_x_ff[COORD_W-1] ? (~prod_x_ff + 32'd1) : prod_x_ff;
      mag_y  = prod_y_ff[COORD_W-1] ? (~prod_y_ff + 32'd1) : prod_y_ff;
      mag_z  = prod_z_ff[COORD_W-1] ? (~prod_z_ff + 32'd1) : prod_z_ff;
      if (mode_a_ff == MODE_DEPTH) begin
         num_b_in[0] = {mag_x, 4'b0000} + {21'd0, den_a_ff[DEN_W-1:1]};
         num_b_in[1] = {mag_y, 4'b0000} + {21'd0, den_a_ff[DEN_W-1:1]};
      end else begin
         num_b_in[0] = {4'b0000, mag_x} + {21'd0, den_a_ff[DEN_W-1:1]};
         num_b_in[1] = {4'b0000, mag_y} + {21'd0, den_a_ff[DEN_W-1:1]};
      end
      // Range mode z is the negated, rounded product scaled down by 1024.
      zround = {1'b0, mag_z} + 33'd512;
      zmag   = {9'd0, zround[COORD_W:10]};
      if (mode_a_ff == MODE_DEPTH) begin
         pz_calc = {12'd0, sample_a_ff, 4'b0000};
      end else if (prod_z_ff[COORD_W-1]) begin
         pz_calc = zmag;
      end else begin
         pz_calc = 32'd0 - zmag;
      end
      side_b_in.neg_x = prod_x_ff[COORD_W-1];
      side_b_in.neg_y = prod_y_ff[COORD_W-1];
      side_b_in.zero  = zero_a_ff;
      side_b_in.pz    = zero_a_ff ? '0 : pz_calc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_b_ff  <= num_b_in;
      den_b_ff  <= den_a_ff;
      side_b_ff <= side_b_in;
   end

   assign out_valid = valid_b_ff;
   assign out_num   = num_b_ff;
   assign out_den   = den_b_ff;
   assign out_side  = side_b_ff;

endmodule

// File: rtl/core/dtp_divider.sv
// Pipelined restoring divider for the x and y lanes, two quotient bits per stage.
// The divisor and a sideband struct ride along; depends on dtp_pkg.
module dtp_divider import dtp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0]            in_den,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][NUM_W-1:0] out_quo,
   output side_type                    out_side
);

   logic [DIV_STAGES-1:0] valid_ff, valid_in;
   logic [DEN_W-1:0]      rem_ff  [DIV_STAGES][LANES];
   logic [DEN_W-1:0]      rem_in  [DIV_STAGES][LANES];
   logic [NUM_W-1:0]      num_ff  [DIV_STAGES][LANES];
   logic [NUM_W-1:0]      num_in  [DIV_STAGES][LANES];
   logic [NUM_W-1:0]      quo_ff  [DIV_STAGES][LANES];
   logic [NUM_W-1:0]      quo_in  [DIV_STAGES][LANES];
   logic [DEN_W-1:0]      den_ff  [DIV_STAGES];
   logic [DEN_W-1:0]      den_in  [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];
   side_type              side_in [DIV_STAGES];

   // Each stage shifts two dividend bits into the remainder and two bits into the quotient.
   always_comb begin
      logic [DEN_W-1:0] r;
      logic [NUM_W-1:0] n;
      logic [NUM_W-1:0] q;
      logic [DEN_W-1:0] d;
      logic [DEN_W:0]   step;
      valid_in = {valid_ff[DIV_STAGES-2:0], in_valid};
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            den_in[k]  = in_den;
            side_in[k] = in_side;
         end else begin
            den_in[k]  = den_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               r = '0;
               n = in_num[l];
               q = '0;
               d = in_den;
            end else begin
               r = rem_ff[k-1][l];
               n = num_ff[k-1][l];
               q = quo_ff[k-1][l];
               d = den_ff[k-1];
            end
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
               step = div_step(r, n[NUM_W-1], d);
               q    = {q[NUM_W-2:0], step[DEN_W]};
               r    = step[DEN_W-1:0];
               n    = {n[NUM_W-2:0], 1'b0};
            end
            rem_in[k][l] = r;
            num_in[k][l] = n;
            quo_in[k][l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      side_ff <= side_in;
   end

   assign out_valid  = valid_ff[DIV_STAGES-1];
   assign out_quo[0] = quo_ff[DIV_STAGES-1][0];
   assign out_quo[1] = quo_ff[DIV_STAGES-1][1];
   assign out_side   = side_ff[DIV_STAGES-1];

endmodule

// File: rtl/core/dtp_out_fifo.sv
// Result buffer between the pipeline and the response channel.
// Holds finished results while the consumer stalls; depends on dtp_pkg.
module dtp_out_fifo import dtp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       out_valid,
   output result_type out_data
);

   result_type         store [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = store[rd_ptr_ff];

endmodule

// File: bench/tb_depth_to_point_cloud.sv
`timescale 1ns / 100ps
// Self-checking bench for the depth to point cloud converter: loads directions, converts
// samples, predicts every point in the bench and compares each response field by field.
// Depends on dtp_pkg and depth_to_point_cloud from rtl/core.
module tb_depth_to_point_cloud;
   import dtp_pkg::*;

   localparam int     LATENCY    = 21;
   localparam int     NUM_PIXELS = 131072;
   localparam longint COORD_HI   = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_LO   = -64'sh0000_0000_8000_0000;

   // Ports of the block under test.
   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata   = '0;    // pixel_index[16:0], dir_x[32:17], dir_y[48:33],
                                     // dir_z[64:49], sample[80:65], zero fill
   logic        req_tuser   = OP_LOAD;   // operation[0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [95:0] rsp_tdata;           // point_x[31:0], point_y[63:32], point_z[95:64]
   logic [1:0]  rsp_tuser;           // status[1:0]
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Bench copy of the registers and of the direction table, entries packed {dz, dy, dx}.
   logic               cfg_mode  = MODE_RESET;
   logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
   logic [ENTRY_W-1:0] dir_copy [int];
   int                 loaded_pixels [$];
   int                 last_loaded = -1;

   // Points predicted for accepted convert requests, oldest first.
   result_type pending_points [$];

   // Traffic shaping shared with the response sink.
   bit feed_idling      = 1'b1;
   bit sink_idling      = 1'b1;
   int sink_hold_cycles = 0;

   // Run statistics.
   int loads_done    = 0;
   int converts_done = 0;
   int points_seen   = 0;
   int zeroed_seen   = 0;
   int saturated_seen = 0;
   int config_writes = 0;
   int fail_count    = 0;

   depth_to_point_cloud #(.PIXELS(NUM_PIXELS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rounds to nearest with ties away from zero; den is positive.
   function automatic longint div_nearest(input longint num, input longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   // Computes the point that one convert request should produce under the current setting.
   function automatic result_type project_point(input logic [ENTRY_W-1:0] entry,
                                                input logic [SAMPLE_W-1:0] depth);
      longint     dx, dy, dz, s, lim, px, py, pz;
      logic       sat;
      result_type r;
      dx  = $signed(entry[DIR_W-1:0]);
      dy  = $signed(entry[2*DIR_W-1:DIR_W]);
      dz  = $signed(entry[3*DIR_W-1:2*DIR_W]);
      s   = depth;
      lim = cfg_limit;
      px  = 0;
      py  = 0;
      pz  = 0;
      sat = 1'b0;
      r.status = STATUS_OK;
      if (cfg_mode == MODE_DEPTH) begin
         if (dz < -lim) begin
            px = div_nearest(dx * s * 16, -dz);
            py = div_nearest(dy * s * 16, -dz);
            pz = s * 16;
            if (px > COORD_HI) begin
               px  = COORD_HI;
               sat = 1'b1;
            end else if (px < COORD_LO) begin
               px  = COORD_LO;
               sat = 1'b1;
            end
            if (py > COORD_HI) begin
               py  = COORD_HI;
               sat = 1'b1;
            end else if (py < COORD_LO) begin
               py  = COORD_LO;
               sat = 1'b1;
            end
            if (sat) begin
               r.status = STATUS_SAT;
            end
         end else begin
            // Degenerate or backward ray: the point is zeroed.
            r.status = STATUS_ZERO;
         end
      end else begin
         px = div_nearest(dx * s, 1024);
         py = div_nearest(dy * s, 1024);
         pz = -div_nearest(dz * s, 1024);
      end
      r.px = px[COORD_W-1:0];
      r.py = py[COORD_W-1:0];
      r.pz = pz[COORD_W-1:0];
      return r;
   endfunction

   // Direction component for x or y, weighted toward the extremes and small values.
   function automatic logic [DIR_W-1:0] rand_axis();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return DIR_W'($urandom_range(0, 16)) - 16'd8;
         default: return DIR_W'($urandom);
      endcase
   endfunction

   // Direction z component: mostly forward rays, some around the near-zero limit.
   function automatic logic [DIR_W-1:0] rand_depth_axis();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 32767);
         1:       v = 0;
         2:       v = -32768;
         3:       v = -(int'(cfg_limit) + $urandom_range(0, 3) - 1);
         default: v = -int'($urandom_range(1, 32768));
      endcase
      return v[DIR_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return SAMPLE_W'($urandom_range(1, 64));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offers one request and waits for its handshake; on acceptance the bench table is
   // updated for a load and a point is predicted for a convert.
   task automatic send_request(input logic op, input logic [PIX_W-1:0] pix,
                               input logic [DIR_W-1:0] dx, dy, dz,
                               input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = 0;
      if (feed_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, smp, dz, dy, dx, pix};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (op == OP_LOAD) begin
         if (!dir_copy.exists(int'(pix))) begin
            loaded_pixels = {loaded_pixels, int'(pix)};
         end
         dir_copy[int'(pix)] = {dz, dy, dx};
         last_loaded = int'(pix);
         loads_done++;
      end else begin
         pending_points = {pending_points, project_point(dir_copy[int'(pix)], smp)};
         converts_done++;
      end
   endtask

   task automatic load_dir(input logic [PIX_W-1:0] pix, input logic [DIR_W-1:0] dx, dy, dz);
      send_request(OP_LOAD, pix, dx, dy, dz, SAMPLE_W'($urandom));
   endtask

   task automatic convert_at(input logic [PIX_W-1:0] pix, input logic [SAMPLE_W-1:0] smp);
      send_request(OP_CONVERT, pix, DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom), smp);
   endtask

   // Converts only ever name pixels that have been loaded; a quarter of them hit the pixel
   // loaded last so that a read right after its write is exercised.
   task automatic send_random_item(input int load_pct);
      logic [PIX_W-1:0] pix;
      if (loaded_pixels.size() == 0 || $urandom_range(0, 99) < load_pct) begin
         if (loaded_pixels.size() == 0 || $urandom_range(0, 1) == 0) begin
            pix = PIX_W'($urandom);
         end else begin
            pix = PIX_W'(loaded_pixels[$urandom_range(0, loaded_pixels.size() - 1)]);
         end
         load_dir(pix, rand_axis(), rand_axis(), rand_depth_axis());
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            pix = PIX_W'(last_loaded);
         end else begin
            pix = PIX_W'(loaded_pixels[$urandom_range(0, loaded_pixels.size() - 1)]);
         end
         convert_at(pix, rand_sample());
      end
   endtask

   // Stops offering requests and waits until every predicted point has arrived, then lets
   // the pipeline run empty.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write on the configuration port, done with the block idle.
   task automatic write_register(input logic idx, input logic [31:0] value);
      settle_block();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_MODE) begin
         cfg_mode = value[0];
      end else begin
         cfg_limit = value[LIMIT_W-1:0];
      end
      config_writes++;
   endtask

   task automatic test_random_traffic(input int count, input int load_pct);
      for (int i = 0; i < count; i++) begin
         send_random_item(load_pct);
      end
   endtask

   // Depth mode at the reset setting: extremes, the limit boundary, backward and flat rays,
   // saturation both ways, zero depth, rounding ties, and a convert right after its load.
   task automatic test_directed_depth();
      load_dir(17'd0,      16'h7FFF, 16'h8000, 16'h8000);
      load_dir(17'd131071, 16'h8000, 16'h7FFF, 16'hFFFF);
      load_dir(17'd1,      16'h7FFF, 16'h8000, 16'hFFFD);
      load_dir(17'd2,      16'h0001, 16'hFFFF, 16'hFFFE);
      load_dir(17'd3,      16'h1234, 16'h4000, 16'h4000);
      load_dir(17'd4,      16'h0001, 16'hFFFF, 16'hFFE0);
      load_dir(17'd5,      16'h4000, 16'h0000, 16'h0000);
      convert_at(17'd0, 16'hFFFF);
      convert_at(17'd0, 16'h0000);
      convert_at(17'd131071, 16'd100);
      convert_at(17'd1, 16'hFFFF);
      convert_at(17'd2, 16'd7);
      convert_at(17'd3, 16'd9);
      convert_at(17'd4, 16'd1);
      convert_at(17'd5, 16'd1000);
      load_dir(17'd65536, 16'h2000, 16'hE000, 16'hC000);
      convert_at(17'd65536, 16'd4000);
      load_dir(17'd65536, 16'hE000, 16'h2000, 16'hA000);
      convert_at(17'd65536, 16'd4000);
   endtask

   // Range mode on the same rays: z negated, no zeroing, and ties at half a unit.
   task automatic test_directed_range();
      write_register(REG_MODE, 32'(MODE_RANGE));
      convert_at(17'd0, 16'hFFFF);
      convert_at(17'd131071, 16'hFFFF);
      convert_at(17'd1, 16'd512);
      convert_at(17'd4, 16'd512);
      convert_at(17'd3, 16'd3000);
   endtask

   // Depth mode across the near-zero limit: the reset value, zero and 16384.
   task automatic test_limit_sweep();
      write_register(REG_MODE, 32'(MODE_DEPTH));
      test_random_traffic(230, 30);
      write_register(REG_LIMIT, 32'd0);
      test_random_traffic(230, 30);
      write_register(REG_LIMIT, 32'd16384);
      test_random_traffic(200, 30);
   endtask

   task automatic test_range_traffic();
      write_register(REG_MODE, 32'(MODE_RANGE));
      write_register(REG_LIMIT, 32'd7);
      test_random_traffic(230, 30);
   endtask

   // The sink holds off for a long stretch while converts keep coming back to back, so the
   // output buffer fills and the request side has to stall.
   task automatic test_backpressure();
      bit saved;
      saved = feed_idling;
      feed_idling = 1'b0;
      sink_hold_cycles = 300;
      for (int i = 0; i < 120; i++) begin
         convert_at(PIX_W'(loaded_pixels[$urandom_range(0, loaded_pixels.size() - 1)]),
                    rand_sample());
      end
      feed_idling = saved;
      settle_block();
   endtask

   // Bursts of traffic with the sender waiting for every result between them.
   task automatic test_drain_pause();
      write_register(REG_MODE, 32'(MODE_DEPTH));
      write_register(REG_LIMIT, 32'($urandom_range(0, 16384)));
      for (int i = 0; i < 4; i++) begin
         test_random_traffic(25, 30);
         settle_block();
      end
   endtask

   // Closing stretch at full rate with no idling on either side.
   task automatic test_steady_stream();
      write_register(REG_LIMIT, 32'(LIMIT_RESET));
      feed_idling = 1'b0;
      sink_idling = 1'b0;
      test_random_traffic(230, 30);
   endtask

   // Response sink: random stalls, calm stretches, and long hold-offs on request.
   initial begin : response_sink
      int stall;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles > 0) begin
            stall = sink_hold_cycles;
            sink_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (sink_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (sink_idling && $urandom_range(0, 39) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compares each accepted response with the oldest predicted point.
   always @(posedge clock) begin : result_check
      result_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         points_seen++;
         if (pending_points.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: unexpected point x=%0d y=%0d z=%0d status=%0d", $realtime,
                        $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                        $signed(rsp_tdata[95:64]), rsp_tuser);
            end
         end else begin
            want = pending_points.pop_front();
            if (want.status == STATUS_ZERO) zeroed_seen++;
            if (want.status == STATUS_SAT) saturated_seen++;
            if (rsp_tdata[31:0] !== want.px || rsp_tdata[63:32] !== want.py ||
                rsp_tdata[95:64] !== want.pz || rsp_tuser !== want.status) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: point mismatch, expected x=%0d y=%0d z=%0d status=%0d",
                           $realtime, $signed(want.px), $signed(want.py), $signed(want.pz),
                           want.status);
                  $display("%0t:                 actual   x=%0d y=%0d z=%0d status=%0d",
                           $realtime, $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                           $signed(rsp_tdata[95:64]), rsp_tuser);
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake or a lost result.
   initial begin : watchdog
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : run
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_depth();
      test_directed_range();
      test_limit_sweep();
      test_range_traffic();
      test_backpressure();
      test_drain_pause();
      test_steady_stream();
      settle_block();
      $display("Covered %0d loads and %0d converts with %0d register writes, both modes,",
               loads_done, converts_done, config_writes);
      $display("limits 0 to 16384; %0d points checked, %0d zeroed, %0d saturated, %0d bad.",
               points_seen, zeroed_seen, saturated_seen, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: depth_to_point_cloud.f
rtl/core/dtp_pkg.sv
rtl/core/dtp_dir_table.sv
rtl/core/dtp_front.sv
rtl/core/dtp_divider.sv
rtl/core/dtp_out_fifo.sv
rtl/core/depth_to_point_cloud.sv
bench/tb_depth_to_point_cloud.sv
